@@ rtl/core/btl_pkg.sv @@
// btl_pkg: shared types and constants for the bakery ticket lock arbiter
`default_nettype none

package btl_pkg;

   localparam int REQ_FUNC_W   = 2;
   localparam int REQ_CLIENT_W = 3;
   localparam int RSP_TICKET_W = 16;

   localparam logic [REQ_FUNC_W-1:0] FUNC_LOCK   = 2'd0;
   localparam logic [REQ_FUNC_W-1:0] FUNC_UNLOCK = 2'd1;
   localparam logic [REQ_FUNC_W-1:0] FUNC_POLL   = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_OWN,
      ST_OWN_DATA,
      ST_MAX,
      ST_MAX_TAIL,
      ST_WRITE,
      ST_WAIT,
      ST_WAIT_TAIL
   } btl_state_type;

   typedef enum logic [1:0] {
      SCAN_NONE,
      SCAN_MAX,
      SCAN_WAIT
   } btl_mode_type;

   typedef struct packed {
      logic         clear;
      logic         live;
      logic         flag;
      btl_mode_type mode;
   } btl_ctrl_type;

endpackage

`default_nettype wire

@@ rtl/core/btl_ram.sv @@
// btl_ram: generic single write, single read ram with registered read data
`default_nettype none

module btl_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule

`default_nettype wire

@@ rtl/core/btl_scan_unit.sv @@
// btl_scan_unit: shared compare unit accumulating the largest ticket or the wait verdict
`default_nettype none

module btl_scan_unit
   import btl_pkg::*;
#(
   parameter int TICKET_BITS = 16,
   parameter int IDX_W       = 3
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire btl_ctrl_type           ctrl,
   input  wire logic [IDX_W-1:0]       idx,
   input  wire logic [IDX_W-1:0]       me_idx,
   input  wire logic [TICKET_BITS-1:0] data,
   input  wire logic [TICKET_BITS-1:0] own,
   output logic      [TICKET_BITS-1:0] max_ticket,
   output logic                        must_wait
);

   logic [TICKET_BITS-1:0] max_ff;
   logic [TICKET_BITS-1:0] max_in;
   logic                   wait_ff;
   logic                   wait_in;
   logic [TICKET_BITS-1:0] opa;
   logic [TICKET_BITS-1:0] opb;
   logic                   gt;
   logic                   eq;

   // one magnitude comparator, operands steered by the scan mode
   always_comb begin
      opa = data;
      opb = max_ff;
      if (ctrl.mode == SCAN_WAIT) begin
         opa = own;
         opb = data;
      end
      gt = opa > opb;
      eq = own == data;
   end

   always_comb begin
      max_in  = max_ff;
      wait_in = wait_ff;
      if (ctrl.clear) begin
         max_in  = '0;
         wait_in = 1'b0;
      end else if (ctrl.live) begin
         case (ctrl.mode)
            SCAN_MAX: begin
               if (gt) begin
                  max_in = data;
               end
            end
            SCAN_WAIT: begin
               if (ctrl.flag && (gt || (eq && (me_idx > idx)))) begin
                  wait_in = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff  <= '0;
         wait_ff <= 1'b0;
      end else begin
         max_ff  <= max_in;
         wait_ff <= wait_in;
      end
   end

   assign max_ticket = max_ff;
   assign must_wait  = wait_ff;

endmodule

`default_nettype wire

@@ rtl/core/bakery_ticket_lock_arbiter.sv @@
// bakery_ticket_lock_arbiter: top level, sequencer, flags and ticket store
//
// Usage
//   A request is a transfer when start is high and busy is low; req_func
//   selects lock, unlock or poll and req_client names the client. Each
//   request gives exactly one response: rsp_valid is high for one cycle with
//   rsp_ticket, rsp_must_wait and rsp_overflow. The receiver cannot stall;
//   the response must be taken in that cycle. busy stays high from the cycle
//   after the transfer up to and including the response cycle.
//   Steps from the transfer to the response:
//     lock        largest ticket pass, write, wait pass
//     poll        own ticket read, wait pass
//     unlock      own ticket read, unused code likewise
//     bad client  response straight from idle
//   One request at a time; the two passes read the ticket ram one entry a
//   cycle through its single read port and the shared compare unit.
//   Reset clears all waiting flags and marks every ticket as zero through
//   per-client valid bits; no clearing pass is needed.
`default_nettype none

module bakery_ticket_lock_arbiter
   import btl_pkg::*;
#(
   parameter int CLIENTS     = 8,
   parameter int TICKET_BITS = 16
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   output logic                         busy,
   input  wire logic [REQ_FUNC_W-1:0]   req_func,
   input  wire logic [REQ_CLIENT_W-1:0] req_client,
   output logic                         rsp_valid,
   output logic      [RSP_TICKET_W-1:0] rsp_ticket,
   output logic                         rsp_must_wait,
   output logic                         rsp_overflow
);

   localparam int IDX_W = $clog2(CLIENTS);
   localparam logic [TICKET_BITS-1:0] TICKET_TOP = '1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CLIENTS - 1);

   btl_state_type state_ff, state_in;
   logic          resp_ff, resp_in;
   logic [REQ_FUNC_W-1:0]   func_ff, func_in;
   logic [REQ_CLIENT_W-1:0] client_ff, client_in;
   logic [IDX_W-1:0]        cnt_ff, cnt_in;
   logic [TICKET_BITS-1:0]  own_ff, own_in;
   logic                    ovf_ff, ovf_in;
   logic                    flags_ff [CLIENTS];
   logic                    valid_ff [CLIENTS];
   logic                    rd_live_ff;
   logic [IDX_W-1:0]        rd_idx_ff;

   logic                    rd_en;
   logic [IDX_W-1:0]        raddr;
   logic                    we;
   logic [TICKET_BITS-1:0]  wdata;
   logic [TICKET_BITS-1:0]  rdata;
   logic [TICKET_BITS-1:0]  rdata_v;
   logic                    flag_set;
   logic                    flag_clr;
   logic [IDX_W-1:0]        me_idx;
   logic [TICKET_BITS-1:0]  max_ticket;
   logic [TICKET_BITS-1:0]  next_ticket;
   logic                    scan_wait;
   btl_ctrl_type            ctrl;

   assign me_idx      = IDX_W'(client_ff);
   assign rdata_v     = valid_ff[rd_idx_ff] ? rdata : '0;
   assign next_ticket = (max_ticket == TICKET_TOP) ? TICKET_TOP : max_ticket + 1'b1;
   assign wdata       = next_ticket;

   btl_ram #(
      .WIDTH (TICKET_BITS),
      .DEPTH (CLIENTS)
   ) u_ticket_ram (
      .clock (clock),
      .we    (we),
      .waddr (me_idx),
      .wdata (wdata),
      .raddr (raddr),
      .rdata (rdata)
   );

   btl_scan_unit #(
      .TICKET_BITS (TICKET_BITS),
      .IDX_W       (IDX_W)
   ) u_scan_unit (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .idx        (rd_idx_ff),
      .me_idx     (me_idx),
      .data       (rdata_v),
      .own        (own_ff),
      .max_ticket (max_ticket),
      .must_wait  (scan_wait)
   );

   always_comb begin
      state_in   = state_ff;
      resp_in    = 1'b0;
      func_in    = func_ff;
      client_in  = client_ff;
      cnt_in     = cnt_ff;
      own_in     = own_ff;
      ovf_in     = ovf_ff;
      rd_en      = 1'b0;
      raddr      = '0;
      we         = 1'b0;
      flag_set   = 1'b0;
      flag_clr   = 1'b0;
      ctrl.clear = 1'b0;
      ctrl.live  = rd_live_ff;
      ctrl.flag  = flags_ff[rd_idx_ff];
      ctrl.mode  = SCAN_NONE;
      busy       = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            busy = resp_ff;
            if (start && !resp_ff) begin
               func_in    = req_func;
               client_in  = req_client;
               own_in     = '0;
               ovf_in     = 1'b0;
               cnt_in     = '0;
               ctrl.clear = 1'b0;
               ctrl.clear = 1'b1;
               if (32'(req_client) >= CLIENTS) begin
                  resp_in  = 1'b1;
                  state_in = ST_IDLE;
               end else if (req_func == FUNC_LOCK) begin
                  state_in = ST_MAX;
               end else begin
                  state_in = ST_OWN;
               end
            end
         end
         ST_OWN: begin
            rd_en    = 1'b1;
            raddr    = me_idx;
            flag_clr = func_ff == FUNC_UNLOCK;
            state_in = ST_OWN_DATA;
         end
         ST_OWN_DATA: begin
            own_in = rdata_v;
            if (func_ff == FUNC_POLL) begin
               state_in = ST_WAIT;
            end else begin
               resp_in  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_MAX: begin
            rd_en     = 1'b1;
            raddr     = cnt_ff;
            ctrl.mode = SCAN_MAX;
            if (cnt_ff == LAST_IDX) begin
               cnt_in   = '0;
               state_in = ST_MAX_TAIL;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_MAX_TAIL: begin
            ctrl.mode = SCAN_MAX;
            state_in  = ST_WRITE;
         end
         ST_WRITE: begin
            we       = 1'b1;
            flag_set = 1'b1;
            own_in   = next_ticket;
            ovf_in   = max_ticket == TICKET_TOP;
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            rd_en     = 1'b1;
            raddr     = cnt_ff;
            ctrl.mode = SCAN_WAIT;
            if (cnt_ff == LAST_IDX) begin
               cnt_in   = '0;
               state_in = ST_WAIT_TAIL;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_WAIT_TAIL: begin
            ctrl.mode = SCAN_WAIT;
            resp_in   = 1'b1;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         resp_ff    <= 1'b0;
         rd_live_ff <= 1'b0;
         ovf_ff     <= 1'b0;
      end else begin
         state_ff   <= state_in;
         resp_ff    <= resp_in;
         rd_live_ff <= rd_en;
         ovf_ff     <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff   <= func_in;
      client_ff <= client_in;
      cnt_ff    <= cnt_in;
      own_ff    <= own_in;
      rd_idx_ff <= raddr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < CLIENTS; k++) begin
            flags_ff[k] <= 1'b0;
            valid_ff[k] <= 1'b0;
         end
      end else begin
         if (flag_set) begin
            flags_ff[me_idx] <= 1'b1;
         end else if (flag_clr) begin
            flags_ff[me_idx] <= 1'b0;
         end
         if (we) begin
            valid_ff[me_idx] <= 1'b1;
         end
      end
   end

   // response strobe is registered from the final sequencer step and shows in the cycle after it
   assign rsp_valid     = resp_ff;
   assign rsp_ticket    = resp_ff ? RSP_TICKET_W'(own_ff) : '0;
   assign rsp_must_wait = resp_ff & scan_wait;
   assign rsp_overflow  = resp_ff & ovf_ff;

endmodule

`default_nettype wire

@@ rtl/core/btl_checker.sv @@
// btl_checker: port level assertions for the bakery ticket lock arbiter, with bind
`default_nettype none

module btl_checker
   import btl_pkg::*;
#(
   parameter int TICKET_BITS = 16
) (
   input wire logic                    clock,
   input wire logic                    reset,
   input wire logic                    start,
   input wire logic                    busy,
   input wire logic                    rsp_valid,
   input wire logic [RSP_TICKET_W-1:0] rsp_ticket,
   input wire logic                    rsp_must_wait,
   input wire logic                    rsp_overflow
);

   localparam logic [TICKET_BITS-1:0] TICKET_TOP = '1;

   // an accepted request keeps the block busy in the next cycle
   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy low after request transfer");

   // a response is a single cycle strobe
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe longer than one cycle");

   // the response cycle is still busy and frees the block next
   a_busy_at_resp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy ##1 !busy)
      else $error("busy wrong around response");

   // saturated ticket shows the top value
   a_ovf_ticket: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_overflow) |-> (rsp_ticket == RSP_TICKET_W'(TICKET_TOP)))
      else $error("overflow without saturated ticket");

   // flags stay quiet outside the response cycle
   a_quiet_outputs: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> (!rsp_must_wait && !rsp_overflow))
      else $error("response flags set without strobe");

endmodule

bind bakery_ticket_lock_arbiter btl_checker #(
   .TICKET_BITS (TICKET_BITS)
) u_btl_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .rsp_valid     (rsp_valid),
   .rsp_ticket    (rsp_ticket),
   .rsp_must_wait (rsp_must_wait),
   .rsp_overflow  (rsp_overflow)
);

`default_nettype wire

@@ sim/tb_bakery_ticket_lock_arbiter.sv @@
`timescale 1ns / 100ps
// tb_bakery_ticket_lock_arbiter: self-checking testbench for the bakery ticket lock arbiter

module tb_bakery_ticket_lock_arbiter;
   import btl_pkg::*;

   localparam int NUM_CLIENTS = 8;
   localparam logic [RSP_TICKET_W-1:0] TICKET_MAX = '1;
   localparam logic [REQ_FUNC_W-1:0] FUNC_SPARE = 2'd3;
   localparam int DIRECTED_ROWS = 25;
   localparam int RANDOM_ITEMS = 1750;
   localparam int TAIL_ITEMS = 150;
   localparam int MAX_GAP = 14;
   localparam int DRAIN_CYCLES = 2 * NUM_CLIENTS + 10;
   localparam int CYCLE_LIMIT = 5_000_000;
   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      logic [REQ_FUNC_W-1:0]   func;
      logic [REQ_CLIENT_W-1:0] client;
      logic                    fixed;
      logic [RSP_TICKET_W-1:0] ticket;
      logic                    must_wait;
      logic                    overflow;
   } lock_request_type;

   typedef struct {
      logic [REQ_FUNC_W-1:0]   func;
      logic [REQ_CLIENT_W-1:0] client;
      logic [RSP_TICKET_W-1:0] ticket;
      logic                    must_wait;
      logic                    overflow;
   } lock_reply_type;

   logic                    clock;
   logic                    reset;
   logic                    start;
   logic                    busy;
   logic [REQ_FUNC_W-1:0]   req_func;
   logic [REQ_CLIENT_W-1:0] req_client;
   logic                    rsp_valid;
   logic [RSP_TICKET_W-1:0] rsp_ticket;
   logic                    rsp_must_wait;
   logic                    rsp_overflow;

   logic                    client_flag [NUM_CLIENTS];
   logic [RSP_TICKET_W-1:0] client_ticket [NUM_CLIENTS];
   lock_reply_type          expected_replies [$];
   int                      fail_count = 0;
   int                      cycle_count = 0;
   logic                    gapless = 1'b0;

   // fixed rows are read straight off the lock rule, the rest go through the predictor
   lock_request_type directed_rows [DIRECTED_ROWS] = '{
      {FUNC_POLL,   3'd0, 1'b1, 16'd0, 1'b0, 1'b0},
      {FUNC_UNLOCK, 3'd7, 1'b1, 16'd0, 1'b0, 1'b0},
      {FUNC_SPARE,  3'd5, 1'b1, 16'd0, 1'b0, 1'b0},
      {FUNC_LOCK,   3'd7, 1'b1, 16'd1, 1'b0, 1'b0},
      {FUNC_LOCK,   3'd0, 1'b1, 16'd2, 1'b1, 1'b0},
      {FUNC_POLL,   3'd0, 1'b1, 16'd2, 1'b1, 1'b0},
      {FUNC_POLL,   3'd7, 1'b1, 16'd1, 1'b0, 1'b0},
      {FUNC_UNLOCK, 3'd7, 1'b1, 16'd1, 1'b0, 1'b0},
      {FUNC_POLL,   3'd0, 1'b1, 16'd2, 1'b0, 1'b0},
      {FUNC_LOCK,   3'd3, 1'b0, 16'd0, 1'b0, 1'b0},
      {FUNC_SPARE,  3'd3, 1'b0, 16'd0, 1'b0, 1'b0},
      {FUNC_UNLOCK, 3'd0, 1'b0, 16'd0, 1'b0, 1'b0},
      {FUNC_POLL,   3'd3, 1'b0, 16'd0, 1'b0, 1'b0},
      {FUNC_LOCK,   3'd5, 1'b0, 16'd0, 1'b0, 1'b0},
      {FUNC_LOCK,   3'd6, 1'b0, 16'd0, 1'b0, 1'b0},
      {FUNC_LOCK,   3'd1, 1'b0, 16'd0, 1'b0, 1'b0},
      {FUNC_POLL,   3'd6, 1'b0, 16'd0, 1'b0, 1'b0},
      {FUNC_UNLOCK, 3'd3, 1'b0, 16'd0, 1'b0, 1'b0},
      {FUNC_POLL,   3'd1, 1'b0, 16'd0, 1'b0, 1'b0},
      {FUNC_UNLOCK, 3'd5, 1'b0, 16'd0, 1'b0, 1'b0},
      {FUNC_POLL,   3'd6, 1'b0, 16'd0, 1'b0, 1'b0},
      {FUNC_POLL,   3'd2, 1'b0, 16'd0, 1'b0, 1'b0},
      {FUNC_UNLOCK, 3'd1, 1'b0, 16'd0, 1'b0, 1'b0},
      {FUNC_UNLOCK, 3'd6, 1'b0, 16'd0, 1'b0, 1'b0},
      {FUNC_LOCK,   3'd4, 1'b0, 16'd0, 1'b0, 1'b0}
   };

   bakery_ticket_lock_arbiter dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_func      (req_func),
      .req_client    (req_client),
      .rsp_valid     (rsp_valid),
      .rsp_ticket    (rsp_ticket),
      .rsp_must_wait (rsp_must_wait),
      .rsp_overflow  (rsp_overflow)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [RSP_TICKET_W-1:0] highest_ticket();
      logic [RSP_TICKET_W-1:0] top;
      top = '0;
      for (int k = 0; k < NUM_CLIENTS; k++) begin
         if (client_ticket[k] > top) begin
            top = client_ticket[k];
         end
      end
      return top;
   endfunction

   function automatic logic client_blocked(int me);
      for (int k = 0; k < NUM_CLIENTS; k++) begin
         if (client_flag[k]) begin
            if (client_ticket[me] > client_ticket[k]) begin
               return 1'b1;
            end
            if (client_ticket[me] == client_ticket[k] && me > k) begin
               return 1'b1;
            end
         end
      end
      return 1'b0;
   endfunction

   function automatic lock_reply_type predict_reply(logic [REQ_FUNC_W-1:0] func,
                                                    logic [REQ_CLIENT_W-1:0] client);
      lock_reply_type reply;
      logic [RSP_TICKET_W-1:0] top;
      reply.func      = func;
      reply.client    = client;
      reply.must_wait = 1'b0;
      reply.overflow  = 1'b0;
      case (func)
         FUNC_LOCK: begin
            top = highest_ticket();
            client_flag[client] = 1'b1;
            if (top == TICKET_MAX) begin
               client_ticket[client] = TICKET_MAX;
               reply.overflow = 1'b1;
            end else begin
               client_ticket[client] = top + 1'b1;
            end
            reply.must_wait = client_blocked(client);
         end
         FUNC_UNLOCK: begin
            client_flag[client] = 1'b0;
         end
         FUNC_POLL: begin
            reply.must_wait = client_blocked(client);
         end
         default: begin
         end
      endcase
      reply.ticket = client_ticket[client];
      return reply;
   endfunction

   // mostly lock, spin, unlock per client; the rest is noise
   function automatic lock_request_type random_request();
      lock_request_type row;
      int c;
      row = '0;
      c = $urandom_range(0, NUM_CLIENTS - 1);
      row.client = REQ_CLIENT_W'(c);
      if ($urandom_range(0, 4) == 0) begin
         row.func = REQ_FUNC_W'($urandom_range(0, 3));
      end else if (!client_flag[c]) begin
         row.func = FUNC_LOCK;
      end else if (client_blocked(c) || $urandom_range(0, 1) == 1) begin
         row.func = FUNC_POLL;
      end else begin
         row.func = FUNC_UNLOCK;
      end
      return row;
   endfunction

   function automatic int draw_gap();
      return gapless ? 0 : $urandom_range(0, MAX_GAP);
   endfunction

   task automatic send_request(input lock_request_type row, input int gap);
      lock_reply_type reply;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start      <= 1'b1;
      req_func   <= row.func;
      req_client <= row.client;
      do @(posedge clock); while (busy);
      reply = predict_reply(row.func, row.client);
      if (row.fixed) begin
         reply.ticket    = row.ticket;
         reply.must_wait = row.must_wait;
         reply.overflow  = row.overflow;
      end
      expected_replies.push_back(reply);
      @(negedge clock);
   endtask

   task automatic wait_for_replies();
      start <= 1'b0;
      @(negedge clock);
      while (expected_replies.size() != 0) @(negedge clock);
   endtask

   initial begin
      int i;
      reset      = 1'b1;
      start      = 1'b0;
      req_func   = FUNC_LOCK;
      req_client = '0;
      for (i = 0; i < NUM_CLIENTS; i++) begin
         client_flag[i]   = 1'b0;
         client_ticket[i] = '0;
      end
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (i = 0; i < DIRECTED_ROWS; i++) begin
         send_request(directed_rows[i], $urandom_range(0, MAX_GAP));
      end
      wait_for_replies();

      for (i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 64 == 0) begin
            gapless = ($urandom_range(0, 3) == 0);
         end
         if (i % 300 == 299) begin
            wait_for_replies();
         end
         send_request(random_request(), draw_gap());
      end

      // short stretch with a faster changing gap pattern
      for (i = 0; i < TAIL_ITEMS; i++) begin
         if (i % 32 == 0) begin
            gapless = ($urandom_range(0, 2) == 0);
         end
         send_request(random_request(), draw_gap());
      end

      wait_for_replies();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   always @(posedge clock) begin
      lock_reply_type want;
      if (!reset && rsp_valid) begin
         if (expected_replies.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS) begin
               $display("unexpected response: ticket %0d must_wait %0b overflow %0b",
                        rsp_ticket, rsp_must_wait, rsp_overflow);
            end
         end else begin
            want = expected_replies.pop_front();
            if (rsp_ticket !== want.ticket || rsp_must_wait !== want.must_wait ||
                rsp_overflow !== want.overflow) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS) begin
                  $display("mismatch func %0d client %0d: ticket %0d/%0d (exp/got)",
                           want.func, want.client, want.ticket, rsp_ticket);
                  $display("   must_wait %0b/%0b overflow %0b/%0b (exp/got)",
                           want.must_wait, rsp_must_wait, want.overflow, rsp_overflow);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("CHECKS FAILED");
         $finish;
      end
   end

endmodule

@@ filelist.f @@
rtl/core/btl_pkg.sv
rtl/core/btl_ram.sv
rtl/core/btl_scan_unit.sv
rtl/core/bakery_ticket_lock_arbiter.sv
rtl/core/btl_checker.sv
sim/tb_bakery_ticket_lock_arbiter.sv
